@@ src/gtp_pkg.sv @@
// ----------------------------------------------------------------------------
// gtp_pkg
// Shared types, constants and helpers of the go-to-pose drive controller.
// ----------------------------------------------------------------------------
`default_nettype none

package gtp_pkg;

  localparam int CORDIC_STEPS = 18;
  localparam int CNT_W        = 5;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;
  localparam int CW           = 36;  // cordic x, y, z width
  localparam int AW           = 23;  // angle arithmetic width

  localparam logic [CNT_W-1:0] CORDIC_LAST = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST   = CNT_W'(31);

  localparam logic signed [AW-1:0] PI16      = 23'sd205887;
  localparam logic signed [AW-1:0] TWO_PI16  = 23'sd411775;
  localparam logic signed [AW-1:0] HALF_PI16 = 23'sd102944;
  localparam logic [31:0]          MIN_DRIVE  = 32'd13107;
  localparam logic [31:0]          STEER_DIST = 32'd19661;

  localparam logic signed [CW-1:0] PI30      = 36'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI30 = 36'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_INV  = 36'sd652032874;

  localparam logic [2:0] REG_MAX_FWD  = 3'd0;
  localparam logic [2:0] REG_MAX_TURN = 3'd1;
  localparam logic [2:0] REG_ARRIVE   = 3'd2;
  localparam logic [2:0] REG_AIM      = 3'd3;
  localparam logic [2:0] REG_FINAL    = 3'd4;

  typedef enum logic [1:0] {
    MODE_FACE  = 2'd0,
    MODE_DRIVE = 2'd1,
    MODE_FINAL = 2'd2,
    MODE_IDLE  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT,
    ST_MULX,
    ST_MULY,
    ST_ADDY,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_SQSUM,
    ST_SQRT,
    ST_VINIT,
    ST_VEC,
    ST_BRG,
    ST_CMD
  } state_e;

  function automatic logic signed [CW-1:0] atan_lut(input logic [CNT_W-1:0] i);
    logic signed [CW-1:0] r;
    case (i)
      5'd0:    r = 36'sd843314857;
      5'd1:    r = 36'sd497837829;
      5'd2:    r = 36'sd263043837;
      5'd3:    r = 36'sd133525159;
      5'd4:    r = 36'sd67021687;
      5'd5:    r = 36'sd33543516;
      5'd6:    r = 36'sd16775851;
      5'd7:    r = 36'sd8388437;
      5'd8:    r = 36'sd4194283;
      5'd9:    r = 36'sd2097149;
      default: r = 36'sd1 <<< (30 - i);
    endcase
    return r;
  endfunction

  // one step is enough for every sum this block forms
  function automatic logic signed [AW-1:0] wrap(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] r;
    if (a > PI16) r = a - TWO_PI16;
    else if (a < -PI16) r = a + TWO_PI16;
    else r = a;
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sd2147483647) r = 32'sh7fffffff;
    else if (v < -38'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [18:0] clamp_rate(input logic signed [18:0] v,
                                                    input logic [17:0] lim);
    logic signed [18:0] l;
    logic signed [18:0] r;
    l = $signed({1'b0, lim});
    if (v < -l) r = -l;
    else if (v > l) r = l;
    else r = v;
    return r;
  endfunction

  function automatic logic below(input logic signed [18:0] v, input logic [17:0] tol);
    logic [18:0] m;
    m = v[18] ? 19'(-v) : 19'(v);
    return m < {1'b0, tol};
  endfunction

endpackage

`default_nettype wire

@@ src/gtp_in_if.sv @@
// ----------------------------------------------------------------------------
// gtp_in_if
// Input channel: odometry samples and goal requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface gtp_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [18:0] heading;
  logic signed [31:0] goal_distance;
  logic signed [18:0] goal_bearing;
  logic signed [18:0] goal_final_heading;

  modport source (output valid, op, pos_x, pos_y, heading, goal_distance,
                  goal_bearing, goal_final_heading, input ready);
  modport sink (input valid, op, pos_x, pos_y, heading, goal_distance,
                goal_bearing, goal_final_heading, output ready);
endinterface

`default_nettype wire

@@ src/gtp_out_if.sv @@
// ----------------------------------------------------------------------------
// gtp_out_if
// Output channel: speed commands.
// ----------------------------------------------------------------------------
`default_nettype none

interface gtp_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] forward_speed;
  logic signed [18:0] turn_rate;
  logic [1:0]         mode;

  modport source (output valid, forward_speed, turn_rate, mode, input ready);
  modport sink (input valid, forward_speed, turn_rate, mode, output ready);
endinterface

`default_nettype wire

@@ src/go_to_pose_drive_controller.sv @@
// ----------------------------------------------------------------------------
// go_to_pose_drive_controller
// Turn, drive, turn go-to-pose controller for a differential-drive base.
// ----------------------------------------------------------------------------
// usage:
//   in_i carries one item per transfer: op 1 is a goal (distance, bearing and
//   final heading relative to the last pose), op 0 an odometry sample.
//   a goal sets the target pose and gives no command; each odometry sample
//   gives one command on out_o (forward speed, turn rate, mode in force).
//   limits and tolerances sit in five APB registers at 4*index.
// datapath:
//   one shared cordic stage does sin/cos and atan2 iteratively; the
//   distance comes from a bit-serial square root.
//   a goal occupies the block until the target is set, an odometry sample
//   until its command is registered; in_i is not ready meanwhile.
// reset and stall:
//   reset clears pose and target to zero and enters idle mode; registers
//   return to their defaults. the command sits in an output register, so a
//   new item is taken while it waits; only the next command waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module go_to_pose_drive_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  gtp_in_if.sink                      in_i,
  gtp_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gtp_pkg::ADDR_W-1:0]  paddr,
  input  logic [gtp_pkg::DATA_W-1:0]  pwdata,
  output logic [gtp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import gtp_pkg::*;

  state_e state_q, state_d;
  mode_e  mode_q, mode_nx;

  logic [22:0] max_fwd_q;
  logic [17:0] max_turn_q;
  logic [22:0] arrive_q;
  logic [17:0] aim_q;
  logic [17:0] final_tol_q;

  logic signed [31:0] pose_x_q, pose_y_q, tgt_x_q, tgt_y_q;
  logic signed [18:0] pose_h_q, tgt_h_q;

  logic signed [31:0] goal_d_q, dx_q, dy_q;
  logic               neg_q, back_q;
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic [CNT_W-1:0]   cnt_q;
  logic signed [66:0] prod_q;
  logic [63:0]        sq_q, sr_q, sb_q;
  logic signed [18:0] brg_q, fin_q;

  logic               out_valid_q;
  logic signed [23:0] fwd_q;
  logic signed [18:0] turn_q;
  mode_e              out_mode_q;

  logic in_acc, out_acc, cfg_wr, out_free;
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_acc  = out_valid_q && out_o.ready;
  assign cfg_wr   = psel && penable && pwrite;
  assign out_free = !out_valid_q || out_o.ready;
  assign pready   = 1'b1;

  // ---------------------------------------------------------------- register read
  always_comb begin
    case (paddr[4:2])
      REG_MAX_FWD:  prdata = DATA_W'(max_fwd_q);
      REG_MAX_TURN: prdata = DATA_W'(max_turn_q);
      REG_ARRIVE:   prdata = DATA_W'(arrive_q);
      REG_AIM:      prdata = DATA_W'(aim_q);
      REG_FINAL:    prdata = DATA_W'(final_tol_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- shared cordic stage
  logic signed [CW-1:0] xs, ys, at, cx_n, cy_n, cz_n;
  logic                 cdir;
  always_comb begin
    xs   = cx_q >>> cnt_q;
    ys   = cy_q >>> cnt_q;
    at   = atan_lut(cnt_q);
    // rotation drives z to zero, vectoring drives y to zero
    cdir = (state_q == ST_ROT) ? !cz_q[CW-1] : cy_q[CW-1];
    if (cdir) begin
      cx_n = cx_q - ys;
      cy_n = cy_q + xs;
      cz_n = cz_q - at;
    end else begin
      cx_n = cx_q + ys;
      cy_n = cy_q - xs;
      cz_n = cz_q + at;
    end
  end

  // ---------------------------------------------------------------- multiplier
  logic signed [32:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [66:0] mul_p;
  logic signed [CW-1:0] cos_v, sin_v;
  assign cos_v = neg_q ? -cx_q : cx_q;
  assign sin_v = neg_q ? -cy_q : cy_q;
  assign mul_p = mul_a * mul_b;

  // ---------------------------------------------------------------- goal entry
  logic signed [AW-1:0] goal_ang, goal_fin;
  logic signed [CW-1:0] goal_z;
  assign goal_ang = wrap(AW'(pose_h_q) + AW'(in_i.goal_bearing));
  assign goal_fin = wrap(AW'(pose_h_q) + AW'(in_i.goal_final_heading));
  assign goal_z   = CW'(goal_ang) <<< 14;

  // rounded offset added to the pose
  logic signed [66:0] rnd_p;
  logic signed [37:0] off_sum;
  logic signed [31:0] pose_sel;
  assign rnd_p    = (prod_q + (67'sd1 <<< 29)) >>> 30;
  assign pose_sel = (state_q == ST_MULY) ? pose_x_q : pose_y_q;
  assign off_sum  = 38'(pose_sel) + rnd_p[37:0];

  // ---------------------------------------------------------------- square root step
  logic [63:0] sq_rb;
  assign sq_rb = sr_q + sb_q;

  // ---------------------------------------------------------------- bearing
  logic signed [CW-1:0] dir_w;
  logic signed [AW-1:0] brg0, brg1, fin0;
  logic                 behind;
  always_comb begin
    dir_w  = (cz_q + 36'sd8192) >>> 14;
    brg0   = wrap(dir_w[AW-1:0] - AW'(pose_h_q));
    behind = (brg0 > HALF_PI16) || (brg0 < -HALF_PI16);
    brg1   = behind ? wrap(brg0 + PI16) : brg0;
    fin0   = wrap(AW'(tgt_h_q) - AW'(pose_h_q));
  end

  // ---------------------------------------------------------------- command
  logic [31:0]        dist_v;
  logic signed [23:0] fwd_c;
  logic signed [18:0] turn_c;
  always_comb begin
    dist_v  = sr_q[31:0];
    fwd_c   = '0;
    turn_c  = '0;
    mode_nx = mode_q;
    case (mode_q)
      MODE_FACE: begin
        turn_c = clamp_rate(brg_q, max_turn_q);
        if (below(brg_q, aim_q)) mode_nx = MODE_DRIVE;
      end
      MODE_DRIVE: begin
        if (!back_q) begin
          if (dist_v < MIN_DRIVE) fwd_c = 24'(MIN_DRIVE);
          else if (dist_v > 32'(max_fwd_q)) fwd_c = 24'(max_fwd_q);
          else fwd_c = dist_v[23:0];
          if (dist_v > STEER_DIST) turn_c = clamp_rate(brg_q, max_turn_q);
        end else begin
          if (dist_v > 32'(max_fwd_q)) fwd_c = -24'(max_fwd_q);
          else if (dist_v < MIN_DRIVE) fwd_c = -24'(MIN_DRIVE);
          else fwd_c = -dist_v[23:0];
        end
        if (dist_v < 32'(arrive_q)) mode_nx = MODE_FINAL;
      end
      MODE_FINAL: begin
        turn_c = clamp_rate(fin_q, max_turn_q);
        if (below(fin_q, final_tol_q)) mode_nx = MODE_IDLE;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = in_i.op ? ST_ROT : ST_DIFF;
      ST_ROT:   if (cnt_q == CORDIC_LAST) state_d = ST_MULX;
      ST_MULX:  state_d = ST_MULY;
      ST_MULY:  state_d = ST_ADDY;
      ST_ADDY:  state_d = ST_IDLE;
      ST_DIFF:  state_d = ST_SQX;
      ST_SQX:   state_d = ST_SQY;
      ST_SQY:   state_d = ST_SQSUM;
      ST_SQSUM: state_d = ST_SQRT;
      ST_SQRT:  if (cnt_q == SQRT_LAST) state_d = ST_VINIT;
      ST_VINIT: state_d = (dx_q == '0 && dy_q == '0) ? ST_BRG : ST_VEC;
      ST_VEC:   if (cnt_q == CORDIC_LAST) state_d = ST_BRG;
      ST_BRG:   state_d = ST_CMD;
      ST_CMD:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      ST_MULX: begin
        mul_a = 33'(goal_d_q);
        mul_b = cos_v[33:0];
      end
      ST_MULY: begin
        mul_a = 33'(goal_d_q);
        mul_b = sin_v[33:0];
      end
      ST_SQX: begin
        mul_a = 33'(dx_q);
        mul_b = 34'(dx_q);
      end
      ST_SQY: begin
        mul_a = 33'(dy_q);
        mul_b = 34'(dy_q);
      end
      default: ;
    endcase
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.forward_speed = fwd_q;
  assign out_o.turn_rate     = turn_q;
  assign out_o.mode          = out_mode_q;

  // ---------------------------------------------------------------- control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_IDLE;
      out_valid_q <= 1'b0;
      max_fwd_q   <= 23'd19661;
      max_turn_q  <= 18'd19661;
      arrive_q    <= 23'd3277;
      aim_q       <= 18'd6554;
      final_tol_q <= 18'd3277;
      pose_x_q    <= '0;
      pose_y_q    <= '0;
      pose_h_q    <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      tgt_h_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        case (paddr[4:2])
          REG_MAX_FWD:  max_fwd_q   <= pwdata[22:0];
          REG_MAX_TURN: max_turn_q  <= pwdata[17:0];
          REG_ARRIVE:   arrive_q    <= pwdata[22:0];
          REG_AIM:      aim_q       <= pwdata[17:0];
          REG_FINAL:    final_tol_q <= pwdata[17:0];
          default: ;
        endcase
      end
      if (in_acc && in_i.op) tgt_h_q <= goal_fin[18:0];
      if (in_acc && !in_i.op) begin
        pose_x_q <= in_i.pos_x;
        pose_y_q <= in_i.pos_y;
        pose_h_q <= in_i.heading;
      end
      if (state_q == ST_MULY) tgt_x_q <= sat32(off_sum);
      if (state_q == ST_ADDY) begin
        tgt_y_q <= sat32(off_sum);
        mode_q  <= MODE_FACE;
      end
      if (state_q == ST_CMD && out_free) begin
        out_valid_q <= 1'b1;
        mode_q      <= mode_nx;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (state_q)
      ST_IDLE: begin
        cnt_q    <= '0;
        goal_d_q <= in_i.goal_distance;
        cx_q     <= GAIN_INV;
        cy_q     <= '0;
        // fold into the right half plane, negate the result afterwards
        if (goal_z > HALF_PI30) begin
          cz_q  <= goal_z - PI30;
          neg_q <= 1'b1;
        end else if (goal_z < -HALF_PI30) begin
          cz_q  <= goal_z + PI30;
          neg_q <= 1'b1;
        end else begin
          cz_q  <= goal_z;
          neg_q <= 1'b0;
        end
      end
      ST_ROT, ST_VEC: begin
        cx_q  <= cx_n;
        cy_q  <= cy_n;
        cz_q  <= cz_n;
        cnt_q <= cnt_q + 1'b1;
      end
      ST_DIFF: begin
        dx_q <= sat32(38'(tgt_x_q) - 38'(pose_x_q));
        dy_q <= sat32(38'(tgt_y_q) - 38'(pose_y_q));
      end
      ST_SQY: sq_q <= prod_q[63:0];
      ST_SQSUM: begin
        sq_q  <= sq_q + prod_q[63:0];
        sr_q  <= '0;
        sb_q  <= 64'd1 << 62;
        cnt_q <= '0;
      end
      ST_SQRT: begin
        if (sq_q >= sq_rb) begin
          sq_q <= sq_q - sq_rb;
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q  <= sb_q >> 2;
        cnt_q <= cnt_q + 1'b1;
      end
      ST_VINIT: begin
        cnt_q <= '0;
        if (dx_q[31]) begin
          cx_q <= -CW'(dx_q);
          cy_q <= -CW'(dy_q);
          cz_q <= dy_q[31] ? -PI30 : PI30;
        end else begin
          cx_q <= CW'(dx_q);
          cy_q <= CW'(dy_q);
          cz_q <= '0;
        end
      end
      ST_BRG: begin
        brg_q  <= brg1[18:0];
        fin_q  <= fin0[18:0];
        back_q <= behind;
      end
      ST_CMD: begin
        if (out_free) begin
          fwd_q      <= fwd_c;
          turn_q     <= turn_c;
          out_mode_q <= mode_q;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- assertions
  a_goal_starts_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.op) |=> (state_q == ST_ROT))
    else $error("goal transfer did not start the rotation");

  a_cmd_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_CMD))
    else $error("command appeared outside the command step");

  a_idle_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_mode_q == MODE_IDLE) |-> (fwd_q == '0 && turn_q == '0))
    else $error("idle command with nonzero speed");

  a_sqrt_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> $onehot(sb_q))
    else $error("square root bit lost");

endmodule

`default_nettype wire
